[rtl/dtks_pkg.sv]
// Shared types and constants for the dual top-k select block.
// No dependencies; dtks_csr and dual_top_k_select_core import this package.
package dtks_pkg;

   localparam int PRICE_W = 32;
   localparam int DAY_W   = 16;
   localparam int CFG_W   = 5;

   localparam logic [DAY_W-1:0] DAY_MAX = '1;

   // one list entry as stored in memory
   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [PRICE_W-1:0] price;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS,
      ST_FIN,
      ST_SCAN,
      ST_PUSH
   } state_type;

   typedef enum logic {
      LIST_LOW  = 1'b0,
      LIST_HIGH = 1'b1
   } list_type;

   typedef enum logic {
      REG_LOW_COUNT  = 1'b0,
      REG_HIGH_COUNT = 1'b1
   } reg_type;

endpackage

[rtl/dtks_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module dtks_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

[rtl/dtks_csr.sv]
// Configuration registers of the dual top-k select block, with range clamping.
// Depends on dtks_pkg.
module dtks_csr
   import dtks_pkg::*;
#(
   parameter int MAX_KEEP = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [2:0]                         csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready,
   output logic [$clog2(MAX_KEEP+1)-1:0]      low_cap,
   output logic [$clog2(MAX_KEEP+1)-1:0]      high_cap
);

   localparam int CW = $clog2(MAX_KEEP + 1);
   localparam logic [CFG_W:0] MAXK = (CFG_W + 1)'(MAX_KEEP);

   logic [CFG_W-1:0] low_count_ff, low_count_in;
   logic [CFG_W-1:0] high_count_ff, high_count_in;
   logic             wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      low_count_in  = low_count_ff;
      high_count_in = high_count_ff;
      if (wr_hit) begin
         if (reg_type'(csr_paddr[2]) == REG_LOW_COUNT) begin
            low_count_in = csr_pwdata[CFG_W-1:0];
         end else begin
            high_count_in = csr_pwdata[CFG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_count_ff  <= CFG_W'(1);
         high_count_ff <= CFG_W'(1);
      end else begin
         low_count_ff  <= low_count_in;
         high_count_ff <= high_count_in;
      end
   end

   always_comb begin
      if (reg_type'(csr_paddr[2]) == REG_LOW_COUNT) begin
         csr_prdata = {{(32-CFG_W){1'b0}}, low_count_ff};
      end else begin
         csr_prdata = {{(32-CFG_W){1'b0}}, high_count_ff};
      end
   end

   // zero acts as one, anything past the list depth acts as the depth
   always_comb begin
      if (low_count_ff == '0) begin
         low_cap = CW'(1);
      end else if ({1'b0, low_count_ff} > MAXK) begin
         low_cap = CW'(MAX_KEEP);
      end else begin
         low_cap = CW'(low_count_ff);
      end
      if (high_count_ff == '0) begin
         high_cap = CW'(1);
      end else if ({1'b0, high_count_ff} > MAXK) begin
         high_cap = CW'(MAX_KEEP);
      end else begin
         high_cap = CW'(high_count_ff);
      end
   end

endmodule

[rtl/dual_top_k_select_core.sv]
// Streaming top-k min/max selection. Each price transaction is numbered by day from 1 and
// inserted into a lowest-price list and a highest-price list, each held price-ordered in its
// own RAM. Insertion walks the held entries through one RAM read port, one entry a cycle,
// and writes each displaced entry one slot down; req_tready is high only between prices.
// After the transaction with tlast the days are sent lowest list first in ascending day
// order, then highest list in descending day order, rsp_tlast on the final one. Each
// result is found by a selection scan over its list. Depends on dtks_pkg, dtks_csr and
// dtks_ram.
module dual_top_k_select_core
   import dtks_pkg::*;
#(
   parameter int MAX_KEEP = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] price
   input  logic        req_tlast,   // final_day
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] day
   output logic        rsp_tuser,   // which_list
   output logic        rsp_tlast,   // last_result
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CW = $clog2(MAX_KEEP + 1);
   localparam int AW = MAX_KEEP > 1 ? $clog2(MAX_KEEP) : 1;
   localparam int KW = DAY_W + AW;

   logic [CW-1:0] low_cap, high_cap;

   dtks_csr #(.MAX_KEEP(MAX_KEEP)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .low_cap     (low_cap),
      .high_cap    (high_cap)
   );

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          low_wr_en, high_wr_en;
   logic [AW-1:0] low_wr_addr, high_wr_addr;
   entry_type     low_wr_data, high_wr_data;
   entry_type     low_rd, high_rd;

   dtks_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_KEEP)) u_low_ram (
      .clock   (clock),
      .wr_en   (low_wr_en),
      .wr_addr (low_wr_addr),
      .wr_data (low_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (low_rd)
   );

   dtks_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_KEEP)) u_high_ram (
      .clock   (clock),
      .wr_en   (high_wr_en),
      .wr_addr (high_wr_addr),
      .wr_data (high_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (high_rd)
   );

   state_type        state_ff, state_in;
   logic [PRICE_W-1:0] price_ff, price_in;
   logic             final_ff, final_in;
   logic [DAY_W-1:0] day_ff, day_in;
   logic [CW-1:0]    nl_ff, nl_in, nh_ff, nh_in;
   logic [CW-1:0]    lfill_ff, lfill_in, hfill_ff, hfill_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic             pend_ff, pend_in;
   logic [AW-1:0]    pidx_ff, pidx_in;
   entry_type        held_l_ff, held_l_in, held_h_ff, held_h_in;
   logic             ins_l_ff, ins_l_in, ins_h_ff, ins_h_in;
   list_type         sel_ff, sel_in;
   logic [CW-1:0]    emit_ff, emit_in;
   logic             first_ff, first_in, found_ff, found_in;
   logic [KW-1:0]    best_ff, best_in, prev_ff, prev_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [DAY_W-1:0] rsp_day_ff, rsp_day_in;
   logic             rsp_which_ff, rsp_which_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [CW-1:0]    nmax, nsel, lnew, hnew;
   logic [DAY_W-1:0] day_next;
   entry_type        sel_rd;
   logic [KW-1:0]    key;
   logic             elig, better;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_day_ff;
   assign rsp_tuser  = rsp_which_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      price_in     = price_ff;
      final_in     = final_ff;
      day_in       = day_ff;
      nl_in        = nl_ff;
      nh_in        = nh_ff;
      lfill_in     = lfill_ff;
      hfill_in     = hfill_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      pidx_in      = idx_ff[AW-1:0];
      held_l_in    = held_l_ff;
      held_h_in    = held_h_ff;
      ins_l_in     = ins_l_ff;
      ins_h_in     = ins_h_ff;
      sel_in       = sel_ff;
      emit_in      = emit_ff;
      first_in     = first_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      prev_in      = prev_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_day_in   = rsp_day_ff;
      rsp_which_in = rsp_which_ff;
      rsp_last_in  = rsp_last_ff;
      req_tready   = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = idx_ff[AW-1:0];
      low_wr_en    = 1'b0;
      high_wr_en   = 1'b0;
      low_wr_addr  = pidx_ff;
      high_wr_addr = pidx_ff;
      low_wr_data  = held_l_ff;
      high_wr_data = held_h_ff;

      nmax     = (nl_ff > nh_ff) ? nl_ff : nh_ff;
      nsel     = (sel_ff == LIST_HIGH) ? nh_ff : nl_ff;
      lnew     = (nl_ff < low_cap) ? nl_ff + CW'(1) : nl_ff;
      hnew     = (nh_ff < high_cap) ? nh_ff + CW'(1) : nh_ff;
      day_next = (day_ff == DAY_MAX) ? day_ff : day_ff + DAY_W'(1);
      sel_rd   = (sel_ff == LIST_HIGH) ? high_rd : low_rd;
      key      = {sel_rd.day, pidx_ff};
      if (sel_ff == LIST_HIGH) begin
         elig   = first_ff || (key < prev_ff);
         better = !found_ff || (key > best_ff);
      end else begin
         elig   = first_ff || (key > prev_ff);
         better = !found_ff || (key < best_ff);
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               price_in  = req_tdata;
               final_in  = req_tlast;
               day_in    = day_next;
               nl_in     = (lfill_ff < low_cap) ? lfill_ff : low_cap;
               nh_in     = (hfill_ff < high_cap) ? hfill_ff : high_cap;
               idx_in    = '0;
               held_l_in = '{day: day_next, price: req_tdata};
               held_h_in = '{day: day_next, price: req_tdata};
               ins_l_in  = 1'b0;
               ins_h_in  = 1'b0;
               state_in  = ST_INS;
            end
         end
         ST_INS: begin
            // read entry idx while entry pidx comes back and is rewritten one behind
            rd_en = idx_ff < nmax;
            if (rd_en) begin
               idx_in  = idx_ff + CW'(1);
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               if (CW'(pidx_ff) < nl_ff &&
                   (ins_l_ff || $signed(price_ff) < $signed(low_rd.price))) begin
                  low_wr_en = 1'b1;
                  held_l_in = low_rd;
                  ins_l_in  = 1'b1;
               end
               if (CW'(pidx_ff) < nh_ff &&
                   (ins_h_ff || $signed(price_ff) > $signed(high_rd.price))) begin
                  high_wr_en = 1'b1;
                  held_h_in  = high_rd;
                  ins_h_in   = 1'b1;
               end
            end
            if (!rd_en && !pend_ff) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // held entry goes to the tail if the list has room, else it falls off
            low_wr_en    = nl_ff < low_cap;
            low_wr_addr  = nl_ff[AW-1:0];
            high_wr_en   = nh_ff < high_cap;
            high_wr_addr = nh_ff[AW-1:0];
            lfill_in     = lnew;
            hfill_in     = hnew;
            if (final_ff) begin
               nl_in    = lnew;
               nh_in    = hnew;
               sel_in   = LIST_LOW;
               emit_in  = '0;
               first_in = 1'b1;
               found_in = 1'b0;
               idx_in   = '0;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            rd_en = idx_ff < nsel;
            if (rd_en) begin
               idx_in  = idx_ff + CW'(1);
               pend_in = 1'b1;
            end
            if (pend_ff && elig && better) begin
               best_in  = key;
               found_in = 1'b1;
            end
            if (!rd_en && !pend_ff) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_day_in   = best_ff[KW-1:AW];
               rsp_which_in = sel_ff;
               rsp_last_in  = (emit_ff == nsel - CW'(1)) &&
                              (sel_ff == LIST_HIGH || nh_ff == '0);
               prev_in      = best_ff;
               first_in     = 1'b0;
               found_in     = 1'b0;
               idx_in       = '0;
               emit_in      = emit_ff + CW'(1);
               state_in     = ST_SCAN;
               if (emit_ff == nsel - CW'(1)) begin
                  if (sel_ff == LIST_LOW && nh_ff != '0) begin
                     sel_in   = LIST_HIGH;
                     emit_in  = '0;
                     first_in = 1'b1;
                  end else begin
                     lfill_in = '0;
                     hfill_in = '0;
                     day_in   = '0;
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         day_ff       <= '0;
         lfill_ff     <= '0;
         hfill_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         day_ff       <= day_in;
         lfill_ff     <= lfill_in;
         hfill_ff     <= hfill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      price_ff     <= price_in;
      final_ff     <= final_in;
      nl_ff        <= nl_in;
      nh_ff        <= nh_in;
      idx_ff       <= idx_in;
      pidx_ff      <= pidx_in;
      held_l_ff    <= held_l_in;
      held_h_ff    <= held_h_in;
      ins_l_ff     <= ins_l_in;
      ins_h_ff     <= ins_h_in;
      sel_ff       <= sel_in;
      emit_ff      <= emit_in;
      first_ff     <= first_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      prev_ff      <= prev_in;
      rsp_day_ff   <= rsp_day_in;
      rsp_which_ff <= rsp_which_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

[bench/dual_top_k_select_core_tb.sv]
// Testbench for dual_top_k_select_core: streams price series, predicts the selected days
// with an in-bench insertion model and checks every result transaction in order.
// Depends on dtks_pkg and the rtl of dual_top_k_select_core.
`timescale 1ns / 1ps

module dual_top_k_select_core_tb;
   import dtks_pkg::*;

   localparam int KEEP = 16;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct {
      logic [15:0] day;
      list_type    which;
      logic        last;
   } day_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   dual_top_k_select_core #(.MAX_KEEP(KEEP)) uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [4:0]          low_keep_reg = 5'd1, high_keep_reg = 5'd1;
   logic signed [31:0]  low_price[KEEP], high_price[KEEP];
   logic [15:0]         low_day[KEEP], high_day[KEEP];
   int                  low_held = 0, high_held = 0;
   logic [15:0]         day_num = 0;
   day_result_type      expected_days[$];

   int  error_count = 0;
   int  cycle_count = 0;
   bit  idle_enable = 1'b1;

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $time, what);
      error_count++;
   endtask

   function automatic int clamp_keep(input logic [4:0] c);
      if (c == 0) return 1;
      if (c > KEEP) return KEEP;
      return c;
   endfunction

   task automatic insert_low(input logic signed [31:0] p, input logic [15:0] d, input int cap);
      int n, pos;
      n = (low_held > cap) ? cap : low_held;
      pos = 0;
      while (pos < n && !(p < low_price[pos])) pos++;
      if (pos >= cap) begin
         low_held = n;
         return;
      end
      if (n == cap) n = cap - 1;
      for (int i = n; i > pos; i--) begin
         low_price[i] = low_price[i-1];
         low_day[i] = low_day[i-1];
      end
      low_price[pos] = p;
      low_day[pos] = d;
      low_held = n + 1;
   endtask

   task automatic insert_high(input logic signed [31:0] p, input logic [15:0] d, input int cap);
      int n, pos;
      n = (high_held > cap) ? cap : high_held;
      pos = 0;
      while (pos < n && !(p > high_price[pos])) pos++;
      if (pos >= cap) begin
         high_held = n;
         return;
      end
      if (n == cap) n = cap - 1;
      for (int i = n; i > pos; i--) begin
         high_price[i] = high_price[i-1];
         high_day[i] = high_day[i-1];
      end
      high_price[pos] = p;
      high_day[pos] = d;
      high_held = n + 1;
   endtask

   task automatic predict_selection(input logic [31:0] price, input logic final_day);
      logic [15:0] days[$];
      day_result_type r;
      if (day_num != 16'hFFFF) day_num++;
      insert_low(price, day_num, clamp_keep(low_keep_reg));
      insert_high(price, day_num, clamp_keep(high_keep_reg));
      if (!final_day) return;
      days.delete();
      for (int i = 0; i < low_held; i++) days = {days, low_day[i]};
      days.sort();
      foreach (days[i]) begin
         r.day = days[i]; r.which = LIST_LOW; r.last = 1'b0;
         expected_days = {expected_days, r};
      end
      days.delete();
      for (int i = 0; i < high_held; i++) days = {days, high_day[i]};
      days.rsort();
      foreach (days[i]) begin
         r.day = days[i]; r.which = LIST_HIGH; r.last = 1'b0;
         expected_days = {expected_days, r};
      end
      if (expected_days.size() > 0) expected_days[$].last = 1'b1;
      day_num = 0;
      low_held = 0;
      high_held = 0;
   endtask

   task automatic random_gap();
      if (idle_enable && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 7)) @(negedge clock);
   endtask

   task automatic send_price(input logic [31:0] price, input logic final_day);
      random_gap();
      // the block is busy the cycle after a transaction, so this costs no throughput
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= price;
      req_tlast <= final_day;
      do @(posedge clock); while (!req_tready);
      predict_selection(price, final_day);
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_days.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(input reg_type idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= 3'(idx) << 2;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_LOW_COUNT) low_keep_reg = value[4:0];
      else high_keep_reg = value[4:0];
      @(negedge clock);
   endtask

   task automatic set_counts(input logic [4:0] lo, input logic [4:0] hi);
      wait_drained();
      write_reg(REG_LOW_COUNT, {27'd0, lo});
      write_reg(REG_HIGH_COUNT, {27'd0, hi});
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      day_result_type e;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("dual_top_k_select_core_tb: done, errors");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_days.size() == 0) report("result transaction with none expected");
         else begin
            e = expected_days.pop_front();
            if (rsp_tdata !== e.day)
               report($sformatf("day got %0d want %0d", rsp_tdata, e.day));
            if (rsp_tuser !== e.which)
               report($sformatf("list got %0b want %0b", rsp_tuser, e.which));
            if (rsp_tlast !== e.last)
               report($sformatf("last got %0b want %0b", rsp_tlast, e.last));
         end
      end
   end

   initial begin
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 4) == 0) begin
            stall = $urandom_range(1, 7) - 1;
            rsp_tready <= 1'b0;
         end else rsp_tready <= 1'b1;
      end
   end

   task automatic test_extremes();
      set_counts(5'd2, 5'd2);
      send_price(32'h8000_0000, 1'b0);
      send_price(32'h7FFF_FFFF, 1'b0);
      send_price(32'h0000_0000, 1'b0);
      send_price(32'hFFFF_FFFF, 1'b0);
      send_price(32'h0000_0001, 1'b1);
      // single-item series
      send_price(32'h1234_5678, 1'b1);
   endtask

   task automatic test_ties_and_short();
      set_counts(5'd4, 5'd3);
      for (int i = 0; i < 6; i++) send_price(32'd5, i == 5);
      // fewer prices than the counts
      set_counts(5'd16, 5'd16);
      send_price(32'd9, 1'b0);
      send_price(-32'sd9, 1'b1);
   endtask

   task automatic test_count_range();
      set_counts(5'd0, 5'd31);
      for (int i = 0; i < 20; i++) send_price($urandom_range(0, 40) - 20, i == 19);
      set_counts(5'd17, 5'd0);
      for (int i = 0; i < 20; i++) send_price($urandom, i == 19);
   endtask

   task automatic test_mid_series_change();
      set_counts(5'd6, 5'd6);
      for (int i = 0; i < 8; i++) send_price($urandom_range(0, 100), 1'b0);
      wait_drained();
      write_reg(REG_LOW_COUNT, 32'd2);
      write_reg(REG_HIGH_COUNT, 32'd3);
      for (int i = 0; i < 4; i++) send_price($urandom_range(0, 100), i == 3);
   endtask

   task automatic test_random();
      int sent, len;
      sent = 0;
      while (sent < 160) begin
         if (sent > 120) idle_enable = 1'b0;
         set_counts($urandom_range(0, 31), $urandom_range(0, 31));
         len = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 3))
               0: send_price($urandom, i == len - 1);
               1: send_price($urandom_range(0, 7) - 3, i == len - 1);
               default: send_price($urandom_range(0, 1000), i == len - 1);
            endcase
         end
         sent += len;
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_extremes();
      test_ties_and_short();
      test_count_range();
      test_mid_series_change();
      test_random();
      wait_drained();
      if (error_count == 0) $display("dual_top_k_select_core_tb: done, clean");
      else $display("dual_top_k_select_core_tb: done, errors");
      $finish;
   end

endmodule
